// ===== hdl/ffa_pkg.sv =====
// Shared types, codes and helpers of the first-fit aligned allocator.
// Used by every module of the block but ffa_ram; depends on nothing else.
package ffa_pkg;

    localparam int unsigned FREE_ENTRIES_DEF  = 64;
    localparam int unsigned ALLOC_ENTRIES_DEF = 64;

    localparam int unsigned ADDR_W  = 35;
    localparam int unsigned ALIGN_W = 13;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [ADDR_W-1:0]  REGION_RESET = 35'd1073741824;
    localparam logic [ALIGN_W-1:0] ALIGN_RESET  = 13'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN  = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] size_bytes;
        logic [ADDR_W-1:0] offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] grant_offset;
        logic [ADDR_W-1:0] used_bytes;
        logic [ADDR_W-1:0] free_bytes;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
    } t_entry;

    typedef struct packed {
        logic       init_wr;
        logic       take;
        logic       k_clr;
        logic       k_inc;
        logic       fr_rd_k;
        logic       fr_rd_k1;
        logic       fr_wr_shift;
        logic       chk_ld;
        logic       fit_ld;
        logic       fc_dec;
        logic       wr_w;
        logic       wr_rem;
        logic       wr_alloc;
        logic       al_rd_k;
        logic       al_rd_k1;
        logic       al_wr_shift;
        logic       sz_ld;
        logic       p_clr;
        logic       p_inc;
        logic       q_clr;
        logic       q_inc;
        logic       fetch_p;
        logic       fetch_q;
        logic       ek_ld;
        logic       q_cmp;
        logic       srt_wr;
        logic       srt_rd;
        logic       mrg_dry;
        logic       mrg_wet;
        logic       mrg_step;
        logic       mrg_fin;
        logic       fin_free;
        logic       res_ld;
        logic [1:0] res_status;
        logic       res_grant;
    } t_ctl_cmd;

    typedef struct packed {
        logic req_free;
        logic k_lt_fc;
        logic k1_lt_fc;
        logic fit;
        logic full_a;
        logic k_lt_ac;
        logic k1_lt_ac;
        logic off_hit;
        logic p_lt_n;
        logic q_lt_n;
        logic wet;
        logic mc_over;
        logic out_free;
    } t_dp_stat;

    function automatic logic pair_less(input t_entry x, input t_entry y);
        return (x.start < y.start) || ((x.start == y.start) && (x.length < y.length));
    endfunction

endpackage

// ===== hdl/ffa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the free, allocated and sorting tables.
module ffa_ram #(
    parameter int unsigned WIDTH = 70,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ffa_ctrl.sv =====
// Sequencer of the allocator: walks the scan, shift, sort and merge steps.
// Depends on ffa_pkg for the command and status structs and the codes.
module ffa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ffa_pkg::t_dp_stat i_stat,
    output ffa_pkg::t_ctl_cmd o_cmd
);

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_A_RD  = 5'd2;
    localparam logic [4:0] S_A_CHK = 5'd3;
    localparam logic [4:0] S_A_FIT = 5'd4;
    localparam logic [4:0] S_A_DEC = 5'd5;
    localparam logic [4:0] S_A_SRD = 5'd6;
    localparam logic [4:0] S_A_SWR = 5'd7;
    localparam logic [4:0] S_A_WW  = 5'd8;
    localparam logic [4:0] S_A_WR  = 5'd9;
    localparam logic [4:0] S_A_AL  = 5'd10;
    localparam logic [4:0] S_F_RD  = 5'd11;
    localparam logic [4:0] S_F_CHK = 5'd12;
    localparam logic [4:0] S_S_KRD = 5'd13;
    localparam logic [4:0] S_S_KLD = 5'd14;
    localparam logic [4:0] S_S_QRD = 5'd15;
    localparam logic [4:0] S_S_QCM = 5'd16;
    localparam logic [4:0] S_S_WR  = 5'd17;
    localparam logic [4:0] S_M_RD  = 5'd18;
    localparam logic [4:0] S_M_ST  = 5'd19;
    localparam logic [4:0] S_M_END = 5'd20;
    localparam logic [4:0] S_D_RD  = 5'd21;
    localparam logic [4:0] S_D_WR  = 5'd22;
    localparam logic [4:0] S_F_FIN = 5'd23;
    localparam logic [4:0] S_DONE  = 5'd24;

    logic [4:0] r_state, n_state;
    logic [1:0] r_code, n_code;
    logic       r_grant, n_grant;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_code  <= ffa_pkg::ST_OK;
            r_grant <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_grant <= n_grant;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_grant = r_grant;
        o_cmd   = '0;
        o_cmd.res_status = r_code;
        o_cmd.res_grant  = r_grant;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take  = 1'b1;
                    o_cmd.k_clr = 1'b1;
                    n_state = i_stat.req_free ? S_F_RD : S_A_RD;
                end
            end
            S_A_RD: begin
                if (!i_stat.k_lt_fc) begin
                    n_code  = ffa_pkg::ST_NO_FIT;
                    n_grant = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.fr_rd_k = 1'b1;
                    n_state = S_A_CHK;
                end
            end
            S_A_CHK: begin
                o_cmd.chk_ld = 1'b1;
                n_state = S_A_FIT;
            end
            S_A_FIT: begin
                if (i_stat.fit) begin
                    o_cmd.fit_ld = 1'b1;
                    n_state = S_A_DEC;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_A_RD;
                end
            end
            S_A_DEC: begin
                if (i_stat.full_a) begin
                    n_code  = ffa_pkg::ST_FULL;
                    n_grant = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_A_SRD;
                end
            end
            S_A_SRD: begin
                if (i_stat.k1_lt_fc) begin
                    o_cmd.fr_rd_k1 = 1'b1;
                    n_state = S_A_SWR;
                end else begin
                    o_cmd.fc_dec = 1'b1;
                    n_state = S_A_WW;
                end
            end
            S_A_SWR: begin
                o_cmd.fr_wr_shift = 1'b1;
                o_cmd.k_inc = 1'b1;
                n_state = S_A_SRD;
            end
            S_A_WW: begin
                o_cmd.wr_w = 1'b1;
                n_state = S_A_WR;
            end
            S_A_WR: begin
                o_cmd.wr_rem = 1'b1;
                n_state = S_A_AL;
            end
            S_A_AL: begin
                o_cmd.wr_alloc = 1'b1;
                n_code  = ffa_pkg::ST_OK;
                n_grant = 1'b1;
                n_state = S_DONE;
            end
            S_F_RD: begin
                if (!i_stat.k_lt_ac) begin
                    n_code  = ffa_pkg::ST_NOT_ALLOC;
                    n_grant = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.al_rd_k = 1'b1;
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (i_stat.off_hit) begin
                    o_cmd.sz_ld = 1'b1;
                    o_cmd.p_clr = 1'b1;
                    n_state = S_S_KRD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_F_RD;
                end
            end
            S_S_KRD: begin
                if (!i_stat.p_lt_n) begin
                    o_cmd.mrg_dry = 1'b1;
                    n_state = S_M_RD;
                end else begin
                    o_cmd.fetch_p = 1'b1;
                    n_state = S_S_KLD;
                end
            end
            S_S_KLD: begin
                o_cmd.ek_ld = 1'b1;
                o_cmd.q_clr = 1'b1;
                n_state = S_S_QRD;
            end
            S_S_QRD: begin
                if (!i_stat.q_lt_n) begin
                    n_state = S_S_WR;
                end else begin
                    o_cmd.fetch_q = 1'b1;
                    n_state = S_S_QCM;
                end
            end
            S_S_QCM: begin
                o_cmd.q_cmp = 1'b1;
                o_cmd.q_inc = 1'b1;
                n_state = S_S_QRD;
            end
            S_S_WR: begin
                o_cmd.srt_wr = 1'b1;
                o_cmd.p_inc = 1'b1;
                n_state = S_S_KRD;
            end
            S_M_RD: begin
                if (!i_stat.p_lt_n) begin
                    n_state = S_M_END;
                end else begin
                    o_cmd.srt_rd = 1'b1;
                    n_state = S_M_ST;
                end
            end
            S_M_ST: begin
                o_cmd.mrg_step = 1'b1;
                o_cmd.p_inc = 1'b1;
                n_state = S_M_RD;
            end
            S_M_END: begin
                if (i_stat.wet) begin
                    o_cmd.mrg_fin = 1'b1;
                    n_state = S_D_RD;
                end else if (i_stat.mc_over) begin
                    n_code  = ffa_pkg::ST_FULL;
                    n_grant = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.mrg_wet = 1'b1;
                    n_state = S_M_RD;
                end
            end
            S_D_RD: begin
                if (i_stat.k1_lt_ac) begin
                    o_cmd.al_rd_k1 = 1'b1;
                    n_state = S_D_WR;
                end else begin
                    n_state = S_F_FIN;
                end
            end
            S_D_WR: begin
                o_cmd.al_wr_shift = 1'b1;
                o_cmd.k_inc = 1'b1;
                n_state = S_D_RD;
            end
            S_F_FIN: begin
                o_cmd.fin_free = 1'b1;
                n_code  = ffa_pkg::ST_OK;
                n_grant = 1'b0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.res_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ffa_dp.sv =====
// Datapath of the allocator: tables, counters, totals, arithmetic and result register.
// Depends on ffa_pkg and on ffa_ram for the three tables.
module ffa_dp #(
    parameter int unsigned FREE_ENTRIES  = ffa_pkg::FREE_ENTRIES_DEF,
    parameter int unsigned ALLOC_ENTRIES = ffa_pkg::ALLOC_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ffa_pkg::t_in_item                  i_in_item,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output ffa_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ffa_pkg::ADDR_W-1:0]         i_cfg_data,
    input  ffa_pkg::t_ctl_cmd                  i_cmd,
    output ffa_pkg::t_dp_stat                  o_stat
);

    localparam int unsigned AW   = ffa_pkg::ADDR_W;
    localparam int unsigned LW   = ffa_pkg::ALIGN_W;
    localparam int unsigned EW   = 2 * AW;
    localparam int unsigned FAW  = $clog2(FREE_ENTRIES);
    localparam int unsigned SDEP = FREE_ENTRIES + 1;
    localparam int unsigned SAW  = $clog2(SDEP);
    localparam int unsigned CW   = $clog2(FREE_ENTRIES + 2);
    localparam int unsigned AAW  = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
    localparam int unsigned ACW  = $clog2(ALLOC_ENTRIES + 1);
    localparam int unsigned MAXE = (FREE_ENTRIES > ALLOC_ENTRIES) ? FREE_ENTRIES : ALLOC_ENTRIES;
    localparam int unsigned IW   = $clog2(MAXE + 2);
    localparam logic [CW-1:0]  FREE_C   = CW'(FREE_ENTRIES);
    localparam logic [CW:0]    FREE_C1  = (CW + 1)'(FREE_ENTRIES + 1);
    localparam logic [ACW-1:0] ALLOC_C  = ACW'(ALLOC_ENTRIES);

    logic [AW-1:0] r_region;
    logic [LW-1:0] r_align;
    logic [CW-1:0] r_fc, r_p, r_q, r_rank, r_mc;
    logic [ACW-1:0] r_ac;
    logic [IW-1:0] r_k;
    logic [AW-1:0] r_used, r_ftot;
    logic          r_out_vld, r_wet, r_fnew;
    ffa_pkg::t_out_item r_out;

    logic [AW:0]   r_sz, r_a, r_lb;
    logic [AW-1:0] r_b, r_off, r_fsz;
    logic [AW+1:0] r_need;
    logic          r_has_w, r_has_rem;
    ffa_pkg::t_entry r_ek, r_ms;
    logic [AW-1:0] r_ml;

    logic [LW-1:0] w_m;
    logic [AW:0]   w_mask, w_sz, w_a, w_lb;
    logic [AW+1:0] w_need;
    logic [IW-1:0] w_k1;
    logic [CW-1:0] w_n;
    logic          w_adj, w_lt, w_cfg_reg;
    ffa_pkg::t_entry w_fr_rd, w_al_rd, w_srt_rd, w_fel, w_new;

    logic            fr_we, fr_re, al_we, al_re;
    logic [FAW-1:0]  fr_waddr, fr_raddr;
    logic [AAW-1:0]  al_waddr, al_raddr;
    ffa_pkg::t_entry fr_wdata, al_wdata;
    logic [EW-1:0]   fr_rdata, al_rdata, srt_rdata;

    assign w_cfg_reg = i_cfg_we && (i_cfg_idx == ffa_pkg::CFG_REGION);
    assign w_m    = (r_align == '0) ? '0 : r_align - LW'(1);
    assign w_mask = ~{{(AW + 1 - LW){1'b0}}, w_m};
    assign w_sz   = ({1'b0, i_in_item.size_bytes} + (AW + 1)'(w_m)) & w_mask;
    assign w_fr_rd  = ffa_pkg::t_entry'(fr_rdata);
    assign w_al_rd  = ffa_pkg::t_entry'(al_rdata);
    assign w_srt_rd = ffa_pkg::t_entry'(srt_rdata);
    assign w_a    = ({1'b0, w_fr_rd.start} + (AW + 1)'(w_m)) & w_mask;
    assign w_lb   = {1'b0, w_fr_rd.length} + {1'b0, w_fr_rd.start};
    assign w_need = {1'b0, r_sz} + {1'b0, r_a};
    assign w_k1   = r_k + IW'(1);
    assign w_n    = r_fc + CW'(1);
    assign w_new  = '{start: r_off, length: r_fsz};
    assign w_fel  = r_fnew ? w_new : w_fr_rd;
    assign w_lt   = ffa_pkg::pair_less(w_fel, r_ek) || ((w_fel == r_ek) && (r_q < r_p));
    assign w_adj  = ({1'b0, r_ms.start} + {1'b0, r_ml}) == {1'b0, w_srt_rd.start};

    always_comb begin
        o_stat = '0;
        o_stat.req_free = (i_in_item.cmd == ffa_pkg::CMD_FREE);
        o_stat.k_lt_fc  = r_k < IW'(r_fc);
        o_stat.k1_lt_fc = w_k1 < IW'(r_fc);
        o_stat.fit      = {1'b0, r_lb} >= w_need;
        o_stat.full_a   = (r_ac >= ALLOC_C) ||
                          (({1'b0, r_fc} + (CW + 1)'(r_has_w) + (CW + 1)'(r_has_rem)) > FREE_C1);
        o_stat.k_lt_ac  = r_k < IW'(r_ac);
        o_stat.k1_lt_ac = w_k1 < IW'(r_ac);
        o_stat.off_hit  = (w_al_rd.start == r_off);
        o_stat.p_lt_n   = r_p < w_n;
        o_stat.q_lt_n   = r_q < w_n;
        o_stat.wet      = r_wet;
        o_stat.mc_over  = r_mc > FREE_C;
        o_stat.out_free = !r_out_vld || i_out_ready;
    end

    always_comb begin
        fr_we    = 1'b0;
        fr_waddr = '0;
        fr_wdata = '0;
        if (w_cfg_reg) begin
            fr_we    = 1'b1;
            fr_wdata = '{start: '0, length: i_cfg_data};
        end else if (i_cmd.init_wr) begin
            fr_we    = 1'b1;
            fr_wdata = '{start: '0, length: r_region};
        end else if (i_cmd.fr_wr_shift) begin
            fr_we    = 1'b1;
            fr_waddr = r_k[FAW-1:0];
            fr_wdata = w_fr_rd;
        end else if (i_cmd.wr_w && r_has_w) begin
            fr_we    = 1'b1;
            fr_waddr = r_fc[FAW-1:0];
            fr_wdata = '{start: r_b, length: AW'(r_a - {1'b0, r_b})};
        end else if (i_cmd.wr_rem && r_has_rem) begin
            fr_we    = 1'b1;
            fr_waddr = r_fc[FAW-1:0];
            fr_wdata = '{start: r_need[AW-1:0], length: AW'({1'b0, r_lb} - r_need)};
        end else if ((i_cmd.mrg_step && r_wet && (r_p != '0) && !w_adj) || i_cmd.mrg_fin) begin
            fr_we    = 1'b1;
            fr_waddr = FAW'(r_mc - CW'(1));
            fr_wdata = '{start: r_ms.start, length: r_ml};
        end
    end

    always_comb begin
        fr_re    = 1'b0;
        fr_raddr = '0;
        if (i_cmd.fr_rd_k) begin
            fr_re    = 1'b1;
            fr_raddr = r_k[FAW-1:0];
        end else if (i_cmd.fr_rd_k1) begin
            fr_re    = 1'b1;
            fr_raddr = w_k1[FAW-1:0];
        end else if (i_cmd.fetch_p) begin
            fr_re    = (r_p != r_fc);
            fr_raddr = r_p[FAW-1:0];
        end else if (i_cmd.fetch_q) begin
            fr_re    = (r_q != r_fc);
            fr_raddr = r_q[FAW-1:0];
        end
    end

    always_comb begin
        al_we    = i_cmd.wr_alloc || i_cmd.al_wr_shift;
        al_waddr = i_cmd.wr_alloc ? r_ac[AAW-1:0] : r_k[AAW-1:0];
        al_wdata = w_al_rd;
        if (i_cmd.wr_alloc) begin
            al_wdata = '{start: r_a[AW-1:0], length: r_sz[AW-1:0]};
        end
        al_re    = i_cmd.al_rd_k || i_cmd.al_rd_k1;
        al_raddr = i_cmd.al_rd_k1 ? w_k1[AAW-1:0] : r_k[AAW-1:0];
    end

    ffa_ram #(.WIDTH(EW), .DEPTH(FREE_ENTRIES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (fr_wdata),
        .i_re    (fr_re),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    ffa_ram #(.WIDTH(EW), .DEPTH(ALLOC_ENTRIES)) u_alloc_ram (
        .i_clk   (i_clk),
        .i_we    (al_we),
        .i_waddr (al_waddr),
        .i_wdata (al_wdata),
        .i_re    (al_re),
        .i_raddr (al_raddr),
        .o_rdata (al_rdata)
    );

    ffa_ram #(.WIDTH(EW), .DEPTH(SDEP)) u_sort_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.srt_wr),
        .i_waddr (r_rank[SAW-1:0]),
        .i_wdata (r_ek),
        .i_re    (i_cmd.srt_rd),
        .i_raddr (r_p[SAW-1:0]),
        .o_rdata (srt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region  <= ffa_pkg::REGION_RESET;
            r_align   <= ffa_pkg::ALIGN_RESET;
            r_fc      <= CW'(1);
            r_ac      <= '0;
            r_used    <= '0;
            r_ftot    <= ffa_pkg::REGION_RESET;
            r_out_vld <= 1'b0;
            r_wet     <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == ffa_pkg::CFG_ALIGN)) begin
                r_align <= i_cfg_data[LW-1:0];
            end
            if (w_cfg_reg) begin
                r_region <= i_cfg_data;
                r_fc     <= CW'(1);
                r_ac     <= '0;
                r_used   <= '0;
                r_ftot   <= i_cfg_data;
            end else begin
                if (i_cmd.fc_dec) begin
                    r_fc <= r_fc - CW'(1);
                end else if ((i_cmd.wr_w && r_has_w) || (i_cmd.wr_rem && r_has_rem)) begin
                    r_fc <= r_fc + CW'(1);
                end else if (i_cmd.mrg_fin) begin
                    r_fc <= r_mc;
                end
                if (i_cmd.wr_alloc) begin
                    r_ac   <= r_ac + ACW'(1);
                    r_used <= r_used + r_sz[AW-1:0];
                    r_ftot <= r_ftot - r_sz[AW-1:0];
                end else if (i_cmd.fin_free) begin
                    r_ac   <= r_ac - ACW'(1);
                    r_used <= r_used - r_fsz;
                    r_ftot <= r_ftot + r_fsz;
                end
            end
            if (i_cmd.mrg_dry) begin
                r_wet <= 1'b0;
            end else if (i_cmd.mrg_wet) begin
                r_wet <= 1'b1;
            end
            if (i_cmd.res_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sz  <= w_sz;
            r_off <= i_in_item.offset;
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= w_k1;
        end
        if (i_cmd.chk_ld) begin
            r_b  <= w_fr_rd.start;
            r_a  <= w_a;
            r_lb <= w_lb;
        end
        if (i_cmd.fit_ld) begin
            r_need    <= w_need;
            r_has_w   <= (r_a != {1'b0, r_b});
            r_has_rem <= ({1'b0, r_lb} > w_need);
        end
        if (i_cmd.sz_ld) begin
            r_fsz <= w_al_rd.length;
        end
        if (i_cmd.p_clr || i_cmd.mrg_dry || i_cmd.mrg_wet) begin
            r_p <= '0;
        end else if (i_cmd.p_inc) begin
            r_p <= r_p + CW'(1);
        end
        if (i_cmd.q_clr) begin
            r_q    <= '0;
            r_rank <= '0;
        end else begin
            if (i_cmd.q_inc) begin
                r_q <= r_q + CW'(1);
            end
            if (i_cmd.q_cmp && w_lt) begin
                r_rank <= r_rank + CW'(1);
            end
        end
        if (i_cmd.fetch_p || i_cmd.fetch_q) begin
            r_fnew <= i_cmd.fetch_p ? (r_p == r_fc) : (r_q == r_fc);
        end
        if (i_cmd.ek_ld) begin
            r_ek <= w_fel;
        end
        if (i_cmd.mrg_step) begin
            if (r_p == '0) begin
                r_ms <= w_srt_rd;
                r_ml <= w_srt_rd.length;
                r_mc <= CW'(1);
            end else if (w_adj) begin
                r_ml <= r_ml + w_srt_rd.length;
            end else begin
                r_ms <= w_srt_rd;
                r_ml <= w_srt_rd.length;
                r_mc <= r_mc + CW'(1);
            end
        end
        if (i_cmd.res_ld) begin
            r_out.status       <= i_cmd.res_status;
            r_out.grant_offset <= i_cmd.res_grant ? r_a[AW-1:0] : '0;
            r_out.used_bytes   <= r_used;
            r_out.free_bytes   <= r_ftot;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= FREE_C)
        else $error("Free table count exceeds its depth.");

    a_ac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ac <= ALLOC_C)
        else $error("Allocated table count exceeds its depth.");

    a_res_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_ld |-> (!r_out_vld || i_out_ready))
        else $error("A result was loaded over one not yet taken.");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.srt_wr |-> (r_rank < w_n))
        else $error("Sort rank falls outside the table being sorted.");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_alloc && !w_cfg_reg) |=> (r_ac == $past(r_ac) + ACW'(1)))
        else $error("Allocation record did not advance the allocated count.");

endmodule

// ===== hdl/first_fit_aligned_allocator_unit.sv =====
// Top level of the first-fit aligned allocator.
// Depends on ffa_pkg, ffa_ctrl, ffa_dp and, through the datapath, ffa_ram.
//
// Usage: one input item per request, cmd selects allocate or free; each item
// yields exactly one result item with status, granted offset and both totals.
// Input and output are valid/ready channels; the result sits in an output
// register, so the next item is taken while a result still waits to be read.
// Items are processed one at a time. Allocate scans the free entries for the
// first fit, then shifts the later free entries down. Free searches the
// allocated entries for the offset, rank-sorts the n = free entries + 1
// elements, makes a dry merge pass and, unless its count overflows the free
// table, a second pass that writes the merged entries, and then shifts the
// later allocated entries down.
// Reset puts one free entry covering the whole region in the table; this is
// written before the first item is accepted. Writing region_bytes
// reinitializes both tables at once; align_bytes only changes the rounding.
// When the receiver stalls, a finished result waits in the output register and
// at most one further item is processed before the block holds its ready low.
module first_fit_aligned_allocator_unit #(
    parameter int unsigned FREE_ENTRIES  = ffa_pkg::FREE_ENTRIES_DEF,
    parameter int unsigned ALLOC_ENTRIES = ffa_pkg::ALLOC_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ffa_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ffa_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ffa_pkg::ADDR_W-1:0]    i_cfg_data
);

    ffa_pkg::t_ctl_cmd ctl_cmd;
    ffa_pkg::t_dp_stat dp_stat;

    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctl_cmd)
    );

    ffa_dp #(
        .FREE_ENTRIES  (FREE_ENTRIES),
        .ALLOC_ENTRIES (ALLOC_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (ctl_cmd),
        .o_stat      (dp_stat)
    );

endmodule

// ===== tb/tb_first_fit_aligned_allocator_unit.sv =====
// Self-checking testbench of the first-fit aligned allocator unit.
// Depends on ffa_pkg and first_fit_aligned_allocator_unit; predicts every result in place.
module tb_first_fit_aligned_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NF = 64;
    localparam int NA = 64;
    localparam int unsigned AW = ffa_pkg::ADDR_W;
    localparam int unsigned LW = ffa_pkg::ALIGN_W;
    localparam int unsigned IXW = ffa_pkg::CFG_IDX_W;
    localparam logic [AW-1:0] ADDR_MAX = '1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    ffa_pkg::t_in_item    i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    ffa_pkg::t_out_item   o_out_item;
    logic                 i_cfg_we;
    logic [IXW-1:0]       i_cfg_idx;
    logic [AW-1:0]        i_cfg_data;

    first_fit_aligned_allocator_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Allocator state mirrored by the predictor.
    logic [AW-1:0]  fr_start [NF];
    logic [AW-1:0]  fr_len [NF];
    logic [AW-1:0]  al_start [NA];
    logic [AW-1:0]  al_len [NA];
    int             fr_cnt;
    int             al_cnt;
    logic [AW-1:0]  used_sum;
    logic [AW-1:0]  free_sum;
    logic [AW-1:0]  region_reg;
    logic [LW-1:0]  align_reg;

    ffa_pkg::t_in_item  pending_items[$];
    ffa_pkg::t_out_item expected_results[$];
    int        idle_in_pct;
    int        idle_out_pct;
    int        hold_left;
    int        err_cnt;
    logic      took;

    task automatic init_tables();
        fr_start[0] = '0;
        fr_len[0] = region_reg;
        fr_cnt = 1;
        al_cnt = 0;
        used_sum = '0;
        free_sum = region_reg;
    endtask

    task automatic apply_reg(input logic [IXW-1:0] idx, input logic [AW-1:0] val);
        if (idx == ffa_pkg::CFG_REGION) begin
            region_reg = val;
            init_tables();
        end else begin
            align_reg = val[LW-1:0];
        end
    endtask

    task automatic try_allocate(input logic [AW-1:0] size, output logic [1:0] st,
                                output logic [AW-1:0] granted);
        logic [63:0] m, sz, b, len, a, w;
        int i, k, pieces;
        bit found;
        m = (align_reg == 0) ? 64'd0 : 64'(align_reg) - 64'd1;
        sz = (64'(size) + m) & ~m;
        found = 0;
        granted = '0;
        b = 0; len = 0; a = 0; w = 0;
        for (i = 0; i < fr_cnt; i++) begin
            b = 64'(fr_start[i]);
            len = 64'(fr_len[i]);
            a = (b + m) & ~m;
            w = a - b;
            if (len >= sz + w) begin
                found = 1;
                break;
            end
        end
        if (!found) begin
            st = ffa_pkg::ST_NO_FIT;
            return;
        end
        pieces = (w > 0 ? 1 : 0) + (len > sz + w ? 1 : 0);
        if (al_cnt >= NA || fr_cnt - 1 + pieces > NF) begin
            st = ffa_pkg::ST_FULL;
            return;
        end
        for (k = i; k + 1 < fr_cnt; k++) begin
            fr_start[k] = fr_start[k+1];
            fr_len[k] = fr_len[k+1];
        end
        fr_cnt--;
        if (w > 0) begin
            fr_start[fr_cnt] = b[AW-1:0];
            fr_len[fr_cnt] = w[AW-1:0];
            fr_cnt++;
        end
        if (len > sz + w) begin
            fr_start[fr_cnt] = 35'(a + sz);
            fr_len[fr_cnt] = 35'(len - sz - w);
            fr_cnt++;
        end
        al_start[al_cnt] = a[AW-1:0];
        al_len[al_cnt] = sz[AW-1:0];
        al_cnt++;
        used_sum = 35'(used_sum + sz);
        free_sum = 35'(free_sum - sz);
        granted = a[AW-1:0];
        st = ffa_pkg::ST_OK;
    endtask

    task automatic try_release(input logic [AW-1:0] off, output logic [1:0] st);
        logic [63:0] ts [NF+1];
        logic [63:0] tl [NF+1];
        logic [63:0] ms [NF+1];
        logic [63:0] ml [NF+1];
        logic [63:0] s, l;
        logic [AW-1:0] sz;
        int j, k, n, p, mc;
        bit found;
        found = 0;
        for (j = 0; j < al_cnt; j++) begin
            if (al_start[j] == off) begin
                found = 1;
                break;
            end
        end
        if (!found) begin
            st = ffa_pkg::ST_NOT_ALLOC;
            return;
        end
        sz = al_len[j];
        n = fr_cnt;
        for (k = 0; k < n; k++) begin
            ts[k] = 64'(fr_start[k]);
            tl[k] = 64'(fr_len[k]);
        end
        ts[n] = 64'(off);
        tl[n] = 64'(sz);
        n++;
        for (k = 1; k < n; k++) begin
            s = ts[k];
            l = tl[k];
            p = k;
            while (p > 0 && (s < ts[p-1] || (s == ts[p-1] && l < tl[p-1]))) begin
                ts[p] = ts[p-1];
                tl[p] = tl[p-1];
                p--;
            end
            ts[p] = s;
            tl[p] = l;
        end
        ms[0] = ts[0];
        ml[0] = tl[0];
        mc = 1;
        for (k = 1; k < n; k++) begin
            if (ms[mc-1] + ml[mc-1] == ts[k]) begin
                ml[mc-1] = (ml[mc-1] + tl[k]) & 64'h7_FFFF_FFFF;
            end else begin
                ms[mc] = ts[k];
                ml[mc] = tl[k];
                mc++;
            end
        end
        if (mc > NF) begin
            st = ffa_pkg::ST_FULL;
            return;
        end
        for (k = 0; k < mc; k++) begin
            fr_start[k] = ms[k][AW-1:0];
            fr_len[k] = ml[k][AW-1:0];
        end
        fr_cnt = mc;
        for (k = j; k + 1 < al_cnt; k++) begin
            al_start[k] = al_start[k+1];
            al_len[k] = al_len[k+1];
        end
        al_cnt--;
        used_sum = 35'(used_sum - sz);
        free_sum = 35'(free_sum + sz);
        st = ffa_pkg::ST_OK;
    endtask

    task automatic predict_result(input ffa_pkg::t_in_item it, output ffa_pkg::t_out_item res);
        logic [1:0] st;
        logic [AW-1:0] granted;
        granted = '0;
        if (it.cmd == ffa_pkg::CMD_ALLOC) begin
            try_allocate(it.size_bytes, st, granted);
        end else begin
            try_release(it.offset, st);
        end
        res.status = st;
        res.grant_offset = (st == ffa_pkg::ST_OK) ? granted : '0;
        res.used_bytes = used_sum;
        res.free_bytes = free_sum;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #1s;
        $display("status: fail");
        $finish;
    end

    // Acceptance of an input item drives the prediction.
    always @(posedge i_clk) begin
        ffa_pkg::t_out_item res;
        took <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_result(i_in_item, res);
            expected_results.insert(expected_results.size(), res);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || took)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
                i_in_item <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= idle_out_pct);
        end
    end

    always @(posedge i_clk) begin
        ffa_pkg::t_out_item exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("unexpected result item %p", o_out_item);
                end
            end else begin
                exp_res = expected_results.pop_front();
                if (o_out_item.status !== exp_res.status
                        || o_out_item.grant_offset !== exp_res.grant_offset
                        || o_out_item.used_bytes !== exp_res.used_bytes
                        || o_out_item.free_bytes !== exp_res.free_bytes) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("mismatch: expected %p actual %p", exp_res, o_out_item);
                    end
                end
            end
        end
    end

    function automatic logic [AW-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[AW-1:0];
    endfunction

    task automatic send(input logic cmd, input logic [AW-1:0] size,
                        input logic [AW-1:0] off);
        ffa_pkg::t_in_item it;
        it.cmd = cmd;
        it.size_bytes = size;
        it.offset = off;
        pending_items.insert(pending_items.size(), it);
    endtask

    // Waits until every queued item has been accepted and its result has come.
    task automatic drain();
        bit busy;
        busy = 1'b1;
        while (busy) begin
            @(posedge i_clk);
            #1;
            busy = (pending_items.size() != 0) || i_in_valid
                   || (expected_results.size() != 0);
        end
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IXW-1:0] idx, input logic [AW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        apply_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n, input logic [AW-1:0] region,
                                input logic [LW-1:0] align);
        logic [AW-1:0] size, off, scale;
        int i;
        drain();
        write_reg(ffa_pkg::CFG_REGION, region);
        write_reg(ffa_pkg::CFG_ALIGN, align);
        for (i = 0; i < n; i++) begin
            wait (pending_items.size() < 2);
            scale = region >> $urandom_range(2, 8);
            if ($urandom_range(99) < 55) begin
                size = (scale == 0) ? rand_addr() % 8 : rand_addr() % (scale + 1);
                if ($urandom_range(99) < 5) size = rand_addr();
                send(ffa_pkg::CMD_ALLOC, size, rand_addr());
            end else begin
                if (al_cnt > 0 && $urandom_range(99) < 85) begin
                    off = al_start[$urandom_range(al_cnt - 1)];
                end else if (al_cnt > 0 && $urandom_range(1)) begin
                    off = al_start[$urandom_range(al_cnt - 1)] + 1;
                end else begin
                    off = rand_addr();
                end
                send(ffa_pkg::CMD_FREE, rand_addr(), off);
            end
            if ($urandom_range(99) < 3) begin
                drain();
                write_reg(ffa_pkg::CFG_ALIGN, 13'd1 << $urandom_range(12));
            end
        end
    endtask

    initial begin
        int i, ph;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = ffa_pkg::CFG_REGION;
        i_cfg_data = '0;
        idle_in_pct = 9;
        idle_out_pct = 72;
        hold_left = 0;
        err_cnt = 0;
        took = 1'b0;
        region_reg = ffa_pkg::REGION_RESET;
        align_reg = ffa_pkg::ALIGN_RESET;
        init_tables();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(ffa_pkg::CMD_ALLOC, '0, '0);
        send(ffa_pkg::CMD_ALLOC, 35'd1, '0);
        send(ffa_pkg::CMD_ALLOC, ADDR_MAX, ADDR_MAX);
        send(ffa_pkg::CMD_ALLOC, 35'd100, '0);
        send(ffa_pkg::CMD_FREE, '0, '0);
        send(ffa_pkg::CMD_FREE, ADDR_MAX, ADDR_MAX);
        send(ffa_pkg::CMD_FREE, '0, 35'd64);
        drain();
        write_reg(ffa_pkg::CFG_ALIGN, 13'd1);
        send(ffa_pkg::CMD_ALLOC, 35'd3, '0);
        drain();
        write_reg(ffa_pkg::CFG_ALIGN, 13'd4096);
        send(ffa_pkg::CMD_ALLOC, 35'd5, '0);
        drain();
        write_reg(ffa_pkg::CFG_ALIGN, 13'd0);
        send(ffa_pkg::CMD_ALLOC, 35'd7, '0);
        drain();
        write_reg(ffa_pkg::CFG_ALIGN, 13'd3);
        send(ffa_pkg::CMD_ALLOC, 35'd5, '0);
        send(ffa_pkg::CMD_FREE, '0, 35'd0);
        drain();
        write_reg(ffa_pkg::CFG_REGION, '0);
        send(ffa_pkg::CMD_ALLOC, '0, '0);
        send(ffa_pkg::CMD_ALLOC, 35'd1, '0);
        drain();
        write_reg(ffa_pkg::CFG_REGION, ADDR_MAX);
        write_reg(ffa_pkg::CFG_ALIGN, 13'h1FFF);
        send(ffa_pkg::CMD_ALLOC, ADDR_MAX, '0);
        drain();
        write_reg(ffa_pkg::CFG_ALIGN, 13'd4096);
        send(ffa_pkg::CMD_ALLOC, ADDR_MAX, '0);
        send(ffa_pkg::CMD_ALLOC, 35'd4095, '0);
        send(ffa_pkg::CMD_FREE, '0, '0);
        drain();

        // Fill the allocation table until it reports full, with a long receiver stall.
        write_reg(ffa_pkg::CFG_REGION, 35'd1024);
        write_reg(ffa_pkg::CFG_ALIGN, 13'd1);
        hold_left = 3000;
        for (i = 0; i < 67; i++) send(ffa_pkg::CMD_ALLOC, 35'd1, '0);
        drain();
        for (i = 0; i < 66; i += 2) send(ffa_pkg::CMD_FREE, '0, 35'(i));
        drain();

        for (ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                idle_in_pct = 72;
                idle_out_pct = 9;
            end else if (ph == 6) begin
                idle_in_pct = 0;
                idle_out_pct = 0;
            end
            case (ph % 3)
                0: random_phase(70, 35'd1 << $urandom_range(12, 20),
                                13'd1 << $urandom_range(12));
                1: random_phase(70, rand_addr(), 13'd1 << $urandom_range(12));
                default: random_phase(70, 35'($urandom_range(65535)),
                                      13'd1 << $urandom_range(6));
            endcase
        end
        drain();
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
